// File: design/scc_pkg.sv
`default_nettype none
package scc_pkg;

    // request opcodes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_CAL    = 2'd1;
    localparam logic [1:0] OP_TOPCAL = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE        = 2'd0;
    localparam logic [1:0] CFG_HARD_CLIP   = 2'd1;
    localparam logic [1:0] CFG_SKIP_FRAMES = 2'd2;
    localparam logic [1:0] CFG_TOTAL_FRMS  = 2'd3;

    // arithmetic widths and constants
    localparam int NUM_W   = 48;   // dividend / radicand high part
    localparam int DEN_W   = 33;   // divisor magnitude
    localparam int VAL_W   = 35;   // unclipped result
    localparam logic signed [15:0] RANGE_LIM = 16'sd80;
    localparam logic signed [VAL_W-1:0] ONE_Q16 = 35'sd65536;

    // start request into the shared divide / square-root unit
    typedef struct packed {
        logic start;
        logic is_sqrt;
    } scc_unit_req_t;

endpackage
`default_nettype wire

// File: design/scc_divsqrt.sv
`default_nettype none
// Shared restoring divider and digit-by-digit square root, one result bit a cycle.
// Divide: num / den over 48 steps. Root: floor(sqrt(num * 2^16)) over 32 steps.
module scc_divsqrt
    import scc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire scc_unit_req_t       req,
    input  wire logic [NUM_W-1:0]    num,
    input  wire logic [DEN_W-1:0]    den,
    output logic                     done,
    output logic [NUM_W-1:0]         res
);
    localparam int REM_W = 36;
    localparam int OPD_W = NUM_W + 16;

    logic [REM_W-1:0] rem_reg;
    logic [OPD_W-1:0] opnd_reg;
    logic [NUM_W-1:0] res_reg;
    logic [DEN_W-1:0] den_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             sqrt_reg;
    logic             done_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    // one step: bring down bits, trial subtract
    always_comb begin
        if (sqrt_reg) begin
            rem_sh = {rem_reg[REM_W-3:0], opnd_reg[OPD_W-1 -: 2]};
            trial  = {res_reg[REM_W-3:0], 2'b01};
        end else begin
            rem_sh = {rem_reg[REM_W-2:0], opnd_reg[OPD_W-1]};
            trial  = REM_W'(den_reg);
        end
        ge = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            sqrt_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                sqrt_reg <= req.is_sqrt;
                cnt_reg  <= req.is_sqrt ? 6'd31 : 6'(NUM_W - 1);
                rem_reg  <= '0;
                res_reg  <= '0;
                opnd_reg <= {num, 16'd0};
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
                res_reg  <= {res_reg[NUM_W-2:0], ge};
                opnd_reg <= sqrt_reg ? {opnd_reg[OPD_W-3:0], 2'b00}
                                     : {opnd_reg[OPD_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
`default_nettype wire

// File: design/sensor_channel_calibrator_core.sv
`default_nettype none
// Per-channel sensor calibrator. A load request writes a channel's bounds and
// coefficients, a calibrate request returns a normalised Q15.16 value with an
// error flag, and a top-calibration request averages samples into the top
// bound. Requests are handled one at a time. Loads, unused opcodes and
// top-calibration requests that add nothing end on acceptance; a summing one
// reads its channel and writes the sum back; a small range or a math error
// sends a calibrate to output with no divide; a linear calibrate and the final
// averaging step wait on a divide and an inverse-square calibrate on a divide,
// then a square root, in the shared one-bit-a-cycle divide / square-root unit
// (48 divide steps, 32 root steps). A result waiting on m_ready holds the next
// calibrate in its output state while stalled. Configuration writes take
// effect at once; make them only while no request is in flight.
module sensor_channel_calibrator_core
    import scc_pkg::*;
#(
    parameter int CHANNELS = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_opcode,
    input  wire logic [4:0]         s_channel,
    input  wire logic signed [15:0] s_sample_value,
    input  wire logic signed [31:0] s_top_value,
    input  wire logic signed [15:0] s_bottom_value,
    input  wire logic signed [31:0] s_coef_a,
    input  wire logic signed [31:0] s_coef_b,
    input  wire logic signed [31:0] s_coef_c,
    input  wire logic               s_frame_end,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [4:0]              m_out_channel,
    output logic signed [31:0]      m_out_value,
    output logic                    m_math_error
);
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_PREP, S_LDIV, S_IDIV, S_SQRT, S_TDIV, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic       mode_reg;
    logic       hard_clip_reg;
    logic [7:0] skip_reg;
    logic [7:0] total_reg;

    // frame bookkeeping
    logic [7:0] frame_count_reg;
    logic       frame_open_reg;

    // channel table
    logic [31:0] top_mem [CHANNELS];
    logic [15:0] bot_mem [CHANNELS];
    logic [31:0] a_mem   [CHANNELS];
    logic [31:0] b_mem   [CHANNELS];
    logic [31:0] c_mem   [CHANNELS];
    logic [CHANNELS-1:0] top_vld_reg;
    logic [CHANNELS-1:0] bot_vld_reg;

    logic [31:0] top_rd_reg;
    logic [15:0] bot_rd_reg;
    logic [31:0] a_rd_reg;
    logic [31:0] b_rd_reg;
    logic [31:0] c_rd_reg;
    logic        top_vld_rd_reg;
    logic        bot_vld_rd_reg;

    // latched request
    logic [AW-1:0]     idx_reg;
    logic [4:0]        ch_reg;
    logic signed [15:0] x_reg;
    logic              is_top_reg;
    logic              tdiv_reg;
    logic [7:0]        tdivisor_reg;
    logic              neg_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic              err_reg;

    // handshake
    logic          accept;
    logic          ch_ok;
    logic [AW-1:0] s_idx;
    logic [8:0]    n_frame;

    // datapath
    logic [31:0]        top_eff;
    logic [15:0]        bot_eff;
    logic [15:0]        range16;
    logic               small_range;
    logic signed [16:0] diff;
    logic [16:0]        diff_mag;
    logic [15:0]        range_mag;
    logic signed [32:0] d_val;
    logic [32:0]        d_mag;
    logic [31:0]        a_mag;
    logic               inv_err;
    logic [31:0]        top_sum;
    logic [31:0]        sum_mag;
    logic [31:0]        tdiv_q;
    logic signed [VAL_W-1:0] val_clip;
    logic               top_we;
    logic [31:0]        top_wdata;

    // unit
    scc_unit_req_t    unit_req;
    logic [NUM_W-1:0] unit_num;
    logic [DEN_W-1:0] unit_den;
    logic             unit_done;
    logic [NUM_W-1:0] unit_res;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign ch_ok   = (32'(s_channel) < CHANNELS);
    assign s_idx   = AW'(s_channel);
    assign n_frame = {1'b0, frame_count_reg} + 9'd1;

    // operand preparation
    always_comb begin
        top_eff     = top_vld_rd_reg ? top_rd_reg : 32'd0;
        bot_eff     = bot_vld_rd_reg ? bot_rd_reg : 16'd0;
        range16     = top_eff[15:0] - bot_eff + 16'd1;
        small_range = ($signed(range16) < RANGE_LIM) && ($signed(range16) > -RANGE_LIM);
        diff        = 17'(x_reg) - 17'($signed(bot_eff));
        diff_mag    = diff[16] ? 17'(-diff) : 17'(diff);
        range_mag   = range16[15] ? (16'd0 - range16) : range16;
        d_val       = (33'(x_reg) <<< 4) - 33'($signed(c_rd_reg));
        d_mag       = d_val[32] ? 33'(-d_val) : 33'(d_val);
        a_mag       = a_rd_reg[31] ? (32'd0 - a_rd_reg) : a_rd_reg;
        inv_err     = (d_val == '0) || ((a_rd_reg != '0) && (a_rd_reg[31] != d_val[32]));
        top_sum     = top_eff + 32'(x_reg);
        sum_mag     = top_sum[31] ? (32'd0 - top_sum) : top_sum;
        tdiv_q      = neg_reg ? (32'd0 - unit_res[31:0]) : unit_res[31:0];
    end

    // unit requests and top write-back
    always_comb begin
        unit_req  = '0;
        unit_num  = '0;
        unit_den  = '0;
        top_we    = 1'b0;
        top_wdata = top_sum;
        unique case (state_reg)
            S_PREP: begin
                if (is_top_reg) begin
                    if (tdiv_reg) begin
                        unit_req.start = 1'b1;
                        unit_num = NUM_W'(sum_mag);
                        unit_den = DEN_W'(tdivisor_reg);
                    end else begin
                        top_we = 1'b1;
                    end
                end else if (!small_range) begin
                    if (!mode_reg) begin
                        unit_req.start = 1'b1;
                        unit_num = NUM_W'({diff_mag, 16'd0});
                        unit_den = DEN_W'(range_mag);
                    end else if (!inv_err) begin
                        unit_req.start = 1'b1;
                        unit_num = NUM_W'({a_mag, 16'd0});
                        unit_den = d_mag;
                    end
                end
            end
            S_IDIV: begin
                if (unit_done) begin
                    unit_req.start   = 1'b1;
                    unit_req.is_sqrt = 1'b1;
                    unit_num         = unit_res;
                end
            end
            S_TDIV: begin
                top_we    = unit_done;
                top_wdata = tdiv_q;
            end
            default: ;
        endcase
    end

    // clip or saturate
    always_comb begin
        if (hard_clip_reg) begin
            if (val_reg < 0)            val_clip = '0;
            else if (val_reg > ONE_Q16) val_clip = ONE_Q16;
            else                        val_clip = val_reg;
        end else begin
            if (val_reg > VAL_W'(32'sh7fffffff))      val_clip = VAL_W'(32'sh7fffffff);
            else if (val_reg < -VAL_W'(33'sh80000000)) val_clip = -VAL_W'(33'sh80000000);
            else                                       val_clip = val_reg;
        end
    end

    scc_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (unit_req),
        .num     (unit_num),
        .den     (unit_den),
        .done    (unit_done),
        .res     (unit_res)
    );

    // channel table
    always_ff @(posedge aclk) begin
        if (accept && (s_opcode == OP_LOAD) && ch_ok) begin
            top_mem[s_idx] <= s_top_value;
            bot_mem[s_idx] <= s_bottom_value;
            a_mem[s_idx]   <= s_coef_a;
            b_mem[s_idx]   <= s_coef_b;
            c_mem[s_idx]   <= s_coef_c;
        end else if (top_we) begin
            top_mem[idx_reg] <= top_wdata;
        end
        top_rd_reg     <= top_mem[idx_reg];
        bot_rd_reg     <= bot_mem[idx_reg];
        a_rd_reg       <= a_mem[idx_reg];
        b_rd_reg       <= b_mem[idx_reg];
        c_rd_reg       <= c_mem[idx_reg];
        top_vld_rd_reg <= top_vld_reg[idx_reg];
        bot_vld_rd_reg <= bot_vld_reg[idx_reg];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            mode_reg        <= 1'b0;
            hard_clip_reg   <= 1'b0;
            skip_reg        <= 8'd4;
            total_reg       <= 8'd32;
            frame_count_reg <= '0;
            frame_open_reg  <= 1'b0;
            top_vld_reg     <= '0;
            bot_vld_reg     <= '0;
            m_valid         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_MODE:        mode_reg      <= cfg_wdata[0];
                    CFG_HARD_CLIP:   hard_clip_reg <= cfg_wdata[0];
                    CFG_SKIP_FRAMES: skip_reg      <= cfg_wdata;
                    CFG_TOTAL_FRMS:  total_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
            // the output state sets valid itself
            if (m_valid && m_ready && (state_reg != S_OUT)) m_valid <= 1'b0;
            if (top_we) top_vld_reg[idx_reg] <= 1'b1;

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        idx_reg    <= s_idx;
                        ch_reg     <= s_channel;
                        x_reg      <= s_sample_value;
                        is_top_reg <= (s_opcode == OP_TOPCAL);
                        if (s_opcode == OP_LOAD) begin
                            if (ch_ok) begin
                                top_vld_reg[s_idx] <= 1'b1;
                                bot_vld_reg[s_idx] <= 1'b1;
                            end
                        end else if (s_opcode == OP_CAL) begin
                            if (ch_ok) state_reg <= S_RD;
                        end else if (s_opcode == OP_TOPCAL) begin
                            if ((frame_count_reg == '0) && !frame_open_reg) top_vld_reg <= '0;
                            if (frame_count_reg < total_reg) begin
                                tdiv_reg     <= (n_frame[7:0] == total_reg);
                                tdivisor_reg <= n_frame[7:0] - skip_reg;
                                if ((n_frame > {1'b0, skip_reg}) && ch_ok) state_reg <= S_RD;
                                if (s_frame_end) frame_count_reg <= n_frame[7:0];
                            end
                            frame_open_reg <= !s_frame_end;
                        end
                    end
                end
                S_RD: state_reg <= S_PREP;
                S_PREP: begin
                    err_reg <= 1'b0;
                    if (is_top_reg) begin
                        neg_reg   <= top_sum[31];
                        state_reg <= tdiv_reg ? S_TDIV : S_IDLE;
                    end else if (small_range) begin
                        val_reg   <= ONE_Q16;
                        state_reg <= S_OUT;
                    end else if (!mode_reg) begin
                        neg_reg   <= (diff[16] != range16[15]);
                        state_reg <= S_LDIV;
                    end else if (inv_err) begin
                        val_reg   <= '0;
                        err_reg   <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_IDIV;
                    end
                end
                S_LDIV: begin
                    if (unit_done) begin
                        val_reg   <= neg_reg ? -VAL_W'(unit_res) : VAL_W'(unit_res);
                        state_reg <= S_OUT;
                    end
                end
                S_IDIV: if (unit_done) state_reg <= S_SQRT;
                S_SQRT: begin
                    if (unit_done) begin
                        val_reg   <= ONE_Q16 + VAL_W'($signed(b_rd_reg))
                                     - $signed(VAL_W'(unit_res[31:0]));
                        state_reg <= S_OUT;
                    end
                end
                S_TDIV: if (unit_done) state_reg <= S_IDLE;
                S_OUT: begin
                    if (!m_valid || m_ready) begin
                        m_valid       <= 1'b1;
                        m_out_channel <= ch_reg;
                        m_out_value   <= val_clip[31:0];
                        m_math_error  <= err_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: design/scc_checker.sv
`default_nettype none
// Port-level checks on the calibrator.
module scc_checker
    import scc_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [1:0]  s_opcode,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_out_value,
    input wire logic        m_math_error
);
    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_value))
        else $error("result changed while stalled");

    // a calibrate request keeps the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == OP_CAL) |=> !s_ready)
        else $error("ready high right after calibrate request");

    // an error result carries zero
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_math_error |-> m_out_value == 32'd0)
        else $error("error result not zero");

    // reset empties the output
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind sensor_channel_calibrator_core scc_checker u_scc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_opcode     (s_opcode),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_value  (m_out_value),
    .m_math_error (m_math_error)
);
`default_nettype wire
